### design/bta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_pkg
// Shared widths, register indexes, reset values and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package bta_pkg;

   localparam int DEFAULT_MAX_SIDE = 2048;

   localparam int CFG_W   = 12;
   localparam int PIXEL_W = 8;
   localparam int COUNT_W = 11;
   localparam int TOTAL_W = 21;
   localparam int CSR_IDX_W = 2;

   localparam int unsigned COUNT_MAX = (1 << COUNT_W) - 1;
   localparam int unsigned TOTAL_MAX = (1 << TOTAL_W) - 1;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = CFG_W'(1024);
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(1024);
   localparam logic             ORIENTATION_RESET  = 1'b0;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_ORIENTATION  = 2'd2
   } bta_reg_type;

   // controller -> datapath
   typedef struct packed {
      logic take;      // accept the pixel on the input
      logic div_step;  // one quotient bit of the end-of-frame divide
      logic rsp_load;  // move the result into the output register
   } bta_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last;      // current position is the frame's last pixel
   } bta_status_type;

endpackage

### design/bta_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_datapath
// Frame position, previous-row memory, transition counter, restoring
// divider for the band average, and the output word register.
// ----------------------------------------------------------------------------
module bta_datapath #(
   parameter int MAX_SIDE = bta_pkg::DEFAULT_MAX_SIDE
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [bta_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bta_pkg::CFG_W-1:0]       csr_write_data,
   input  logic [bta_pkg::PIXEL_W-1:0]     req_pixel,
   input  bta_pkg::bta_cmd_type            cmd,
   output bta_pkg::bta_status_type         status,
   output logic [bta_pkg::COUNT_W-1:0]     rsp_thread_count,
   output logic [bta_pkg::TOTAL_W-1:0]     rsp_transition_total
);
   import bta_pkg::*;

   localparam int IDX_W  = $clog2(MAX_SIDE);
   localparam int SIDE_W = IDX_W + 1;
   localparam int SUM_W  = 2 * IDX_W;
   localparam int NUM_W  = SUM_W + 2;
   localparam int DEN_W  = SIDE_W + 1;

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
      int unsigned t;
      t = 32'(v);
      if (t == 0) t = 1;
      else if (t > MAX_SIDE) t = MAX_SIDE;
      return t[SIDE_W-1:0];
   endfunction

   // configuration
   logic [CFG_W-1:0] frame_width_ff, frame_height_ff;
   logic             orientation_ff;

   // frame position and counter
   logic [IDX_W-1:0]   col_ff, col_in, row_ff, row_in;
   logic [SUM_W-1:0]   total_ff, total_in, total_new;
   logic [PIXEL_W-1:0] left_ff;

   // previous-row memory
   logic [PIXEL_W-1:0] row_mem [MAX_SIDE];
   logic [PIXEL_W-1:0] mem_q_ff, prev_px;
   logic [IDX_W-1:0]   rd_addr;
   logic               bypass_ff;

   // divider and output
   logic [NUM_W-1:0]   num_ff;
   logic [DEN_W-1:0]   den_ff, rem_ff;
   logic [DEN_W:0]     rem_shift;
   logic               q_bit;
   logic [SUM_W-1:0]   tot_hold_ff;
   logic [COUNT_W-1:0] count_out_ff;
   logic [TOTAL_W-1:0] total_out_ff;

   logic [SIDE_W-1:0]   side_w, side_h, side, lo, hi, band;
   logic [SIDE_W+1:0]   lo_sum, hi_sum;
   logic [SIDE_W-1:0]   col_ext, row_ext;
   logic                last_col, last_row, in_band, step;
   logic                csr_hit;
   logic [31:0]         avg_ext, tot_ext;

   assign side_w = clamp_side(frame_width_ff);
   assign side_h = clamp_side(frame_height_ff);
   assign side   = orientation_ff ? side_h : side_w;
   assign lo_sum = {2'b00, side} + (SIDE_W+2)'(2);
   assign hi_sum = {1'b0, side, 1'b0} + {2'b00, side} + (SIDE_W+2)'(2);
   assign lo     = lo_sum[SIDE_W+1:2];
   assign hi     = hi_sum[SIDE_W+1:2];
   assign band   = hi - lo;

   assign col_ext  = {1'b0, col_ff};
   assign row_ext  = {1'b0, row_ff};
   assign last_col = (col_ext + SIDE_W'(1)) == side_w;
   assign last_row = (row_ext + SIDE_W'(1)) == side_h;
   assign status.last = last_col && last_row;

   // only writes to a mapped register restart the frame
   assign csr_hit = csr_write_enable && (csr_index == REG_FRAME_WIDTH ||
                                         csr_index == REG_FRAME_HEIGHT ||
                                         csr_index == REG_ORIENTATION);

   // single-column frames read back the word just written
   assign prev_px = bypass_ff ? left_ff : mem_q_ff;

   always_comb begin
      if (orientation_ff) begin
         in_band = (col_ff != '0) && (row_ext >= lo) && (row_ext < hi);
         step    = left_ff < req_pixel;
      end else begin
         in_band = (row_ff != '0) && (col_ext >= lo) && (col_ext < hi);
         step    = prev_px < req_pixel;
      end
      total_new = total_ff + SUM_W'(in_band && step);
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      total_in = total_ff;
      if (csr_hit) begin
         col_in   = '0;
         row_in   = '0;
         total_in = '0;
      end else if (cmd.take) begin
         if (!last_col) begin
            col_in   = col_ff + IDX_W'(1);
            total_in = total_new;
         end else if (!last_row) begin
            col_in   = '0;
            row_in   = row_ff + IDX_W'(1);
            total_in = total_new;
         end else begin
            col_in   = '0;
            row_in   = '0;
            total_in = '0;
         end
      end
      rd_addr = cmd.take ? col_in : col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         orientation_ff  <= ORIENTATION_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         total_ff        <= '0;
         bypass_ff       <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               REG_FRAME_WIDTH:  frame_width_ff  <= csr_write_data;
               REG_FRAME_HEIGHT: frame_height_ff <= csr_write_data;
               REG_ORIENTATION:  orientation_ff  <= csr_write_data[0];
               default: ;
            endcase
         end
         col_ff    <= col_in;
         row_ff    <= row_in;
         total_ff  <= total_in;
         bypass_ff <= cmd.take && (col_in == col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         row_mem[col_ff] <= req_pixel;
         left_ff         <= req_pixel;
      end
      mem_q_ff <= row_mem[rd_addr];
   end

   // restoring divide: (2*total + band) / (2*band), quotient shifts into num
   assign rem_shift = {rem_ff, num_ff[NUM_W-1]};
   assign q_bit     = rem_shift >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (cmd.take && status.last) begin
         num_ff      <= {1'b0, total_new, 1'b0} + NUM_W'(band);
         den_ff      <= {band, 1'b0};
         rem_ff      <= '0;
         tot_hold_ff <= total_new;
      end else if (cmd.div_step) begin
         rem_ff <= q_bit ? DEN_W'(rem_shift - {1'b0, den_ff}) : rem_shift[DEN_W-1:0];
         num_ff <= {num_ff[NUM_W-2:0], q_bit};
      end
   end

   assign avg_ext = 32'(num_ff);
   assign tot_ext = 32'(tot_hold_ff);

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         count_out_ff <= (avg_ext > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : avg_ext[COUNT_W-1:0];
         total_out_ff <= (tot_ext > TOTAL_MAX) ? TOTAL_W'(TOTAL_MAX) : tot_ext[TOTAL_W-1:0];
      end
   end

   assign rsp_thread_count     = count_out_ff;
   assign rsp_transition_total = total_out_ff;

endmodule

### design/bta_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_controller
// Sequences pixel intake, the end-of-frame divide and the output word
// handshake.
// ----------------------------------------------------------------------------
module bta_controller #(
   parameter int MAX_SIDE = bta_pkg::DEFAULT_MAX_SIDE
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  bta_pkg::bta_status_type status,
   output bta_pkg::bta_cmd_type    cmd
);
   import bta_pkg::*;

   localparam int NUM_W = 2 * $clog2(MAX_SIDE) + 2;
   localparam int CNT_W = $clog2(NUM_W);

   typedef enum logic [1:0] {
      ST_RUN,
      ST_DIV,
      ST_SEND
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_RUN: begin
            cmd.take = req_valid;
            if (req_valid && status.last) begin
               state_in = ST_DIV;
               cnt_in   = '0;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) state_in = ST_SEND;
         end
         ST_SEND: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_RUN;
   assign rsp_valid = rsp_valid_ff;

endmodule

### design/band_transition_averager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// band_transition_averager
// Counts rising pixel steps inside the middle band of a raster frame and
// reports the total and the rounded per-profile average once per frame.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle, when not stalled, in raster order; the
// previous row lives in a MAX_SIDE x 8 memory with one write and one
// registered read per cycle, read one column ahead. After a frame's last pixel
// the input is stalled while a one-bit-per-cycle restoring divider forms the
// average and the result moves to the output register, and further while the
// previous result has not yet been taken. Pixel intake then resumes while the
// result waits. No clearing pass after reset. A write to a mapped register
// restarts the frame; write only while idle.
module band_transition_averager #(
   parameter int MAX_SIDE = bta_pkg::DEFAULT_MAX_SIDE
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [bta_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bta_pkg::CFG_W-1:0]      csr_write_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [bta_pkg::PIXEL_W-1:0]    req_pixel,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bta_pkg::COUNT_W-1:0]    rsp_thread_count,
   output logic [bta_pkg::TOTAL_W-1:0]    rsp_transition_total
);
   import bta_pkg::*;

   bta_cmd_type    cmd;
   bta_status_type status;

   bta_controller #(
      .MAX_SIDE (MAX_SIDE)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bta_datapath #(
      .MAX_SIDE (MAX_SIDE)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_pixel            (req_pixel),
      .cmd                  (cmd),
      .status               (status),
      .rsp_thread_count     (rsp_thread_count),
      .rsp_transition_total (rsp_transition_total)
   );

endmodule

### tb/band_transition_averager_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// band_transition_averager_tb
// Streams pixel frames of many sizes and both orientations through the
// averager under random input gaps and output stalls. A scoreboard follows
// every accepted word with its own model of the band step count and checks
// each end-of-frame total and average as it is taken.
// ----------------------------------------------------------------------------
module band_transition_averager_tb;
   import bta_pkg::*;

   localparam int MAX_SIDE      = DEFAULT_MAX_SIDE;
   localparam int SETTLE_CYCLES = 45;    // end-of-frame divide plus margin
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 4000;
   localparam int RANDOM_ITEMS  = 1500;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;   // unmapped index

   typedef enum int {PAT_NOISE, PAT_RAMP, PAT_FLAT, PAT_TOGGLE, PAT_LOWBITS} pattern_type;

   typedef struct packed {
      logic [COUNT_W-1:0] thread_count;
      logic [TOTAL_W-1:0] transition_total;
   } frame_result_type;

   class transition_scoreboard;
      logic [PIXEL_W-1:0] prev_row [MAX_SIDE];
      logic [PIXEL_W-1:0] left_px;
      int unsigned        col_pos;
      int unsigned        row_pos;
      int unsigned        step_sum;
      logic [CFG_W-1:0]   width_reg;
      logic [CFG_W-1:0]   height_reg;
      logic               orient_reg;
      frame_result_type   expected_q [$];
      int                 errors;

      function new();
         foreach (prev_row[i]) prev_row[i] = '0;
         width_reg  = FRAME_WIDTH_RESET;
         height_reg = FRAME_HEIGHT_RESET;
         orient_reg = ORIENTATION_RESET;
         errors     = 0;
         restart();
      endfunction

      function void restart();
         col_pos  = 0;
         row_pos  = 0;
         step_sum = 0;
         left_px  = '0;
      endfunction

      function int unsigned clamp_side(logic [CFG_W-1:0] v);
         if (v == 0) return 1;
         if (v > MAX_SIDE) return MAX_SIDE;
         return v;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
         case (idx)
            REG_FRAME_WIDTH:  width_reg  = data;
            REG_FRAME_HEIGHT: height_reg = data;
            REG_ORIENTATION:  orient_reg = data[0];
            default:          return;
         endcase
         restart();
      endfunction

      function void note_pixel(logic [PIXEL_W-1:0] px);
         int unsigned      w, h, side, lo, hi, band, c, r, avg, tot;
         frame_result_type res;
         w    = clamp_side(width_reg);
         h    = clamp_side(height_reg);
         side = orient_reg ? h : w;
         lo   = (side + 2) / 4;
         hi   = (3 * side + 2) / 4;
         band = hi - lo;
         c    = (col_pos >= w) ? w - 1 : col_pos;
         r    = (row_pos >= h) ? h - 1 : row_pos;
         if (!orient_reg) begin
            if (r >= 1 && c >= lo && c < hi && prev_row[c] < px) step_sum++;
         end else begin
            if (c >= 1 && r >= lo && r < hi && left_px < px) step_sum++;
         end
         prev_row[c] = px;
         left_px     = px;
         if (c + 1 < w) begin
            col_pos = c + 1;
            row_pos = r;
         end else if (r + 1 < h) begin
            col_pos = 0;
            row_pos = r + 1;
         end else begin
            tot = step_sum;
            avg = (band != 0) ? (2 * tot + band) / (2 * band) : 0;
            if (avg > COUNT_MAX) avg = COUNT_MAX;
            if (tot > TOTAL_MAX) tot = TOTAL_MAX;
            res.thread_count     = avg[COUNT_W-1:0];
            res.transition_total = tot[TOTAL_W-1:0];
            expected_q.push_back(res);
            restart();
         end
      endfunction

      function void check_result(logic [COUNT_W-1:0] count, logic [TOTAL_W-1:0] total);
         frame_result_type exp_res;
         if (expected_q.size() == 0) begin
            $error("unexpected result: thread_count %0d transition_total %0d", count, total);
            errors++;
            return;
         end
         exp_res = expected_q.pop_front();
         if (count !== exp_res.thread_count) begin
            $error("thread_count: expected %0d, got %0d", exp_res.thread_count, count);
            errors++;
         end
         if (total !== exp_res.transition_total) begin
            $error("transition_total: expected %0d, got %0d",
                   exp_res.transition_total, total);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CFG_W-1:0]      csr_write_data;
   logic                  req_valid;
   logic                  req_stall;
   logic [PIXEL_W-1:0]    req_pixel;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [COUNT_W-1:0]    rsp_thread_count;
   logic [TOTAL_W-1:0]    rsp_transition_total;

   transition_scoreboard sb = new();
   int  pixels_sent = 0;
   int  idle_cycles = 0;
   bit  gaps_on     = 1'b1;
   bit  hold_req    = 1'b0;
   bit  in_hold     = 1'b0;

   band_transition_averager dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_pixel            (req_pixel),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_thread_count     (rsp_thread_count),
      .rsp_transition_total (rsp_transition_total)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_thread_count, rsp_transition_total);
   end

   // watchdog: cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // receiver back-pressure
   initial begin
      int len;
      int pick;
      forever begin
         if (hold_req) begin
            in_hold = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
            in_hold  = 1'b0;
         end else begin
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
               rsp_stall <= 1'b0;
               len = $urandom_range(30, 150);
            end else if (pick == 1) begin
               rsp_stall <= 1'b1;
               len = $urandom_range(10, 40);
            end else begin
               rsp_stall <= ($urandom_range(0, 2) == 0);
               len = $urandom_range(1, 3);
            end
            repeat (len) @(posedge clock);
         end
      end
   end

   function automatic logic [PIXEL_W-1:0] pattern_pixel(pattern_type mode, int pos,
                                                        logic [PIXEL_W-1:0] base);
      case (mode)
         PAT_NOISE:  return PIXEL_W'($urandom);
         PAT_RAMP:   return base + PIXEL_W'(pos * 3);
         PAT_FLAT:   return base;
         PAT_TOGGLE: return pos[0] ? 8'hFF : 8'h00;
         default:    return PIXEL_W'($urandom_range(0, 3));
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] pick_side();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return CFG_W'($urandom_range(13, 40));
      return CFG_W'($urandom_range(1, 12));
   endfunction

   task automatic send_pixel(input logic [PIXEL_W-1:0] px);
      int gap;
      gap = 0;
      if (gaps_on && $urandom_range(0, 9) >= 7)
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_pixel(px);
      pixels_sent++;
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      sb.write_reg(idx, data);
      @(posedge clock);
   endtask

   // writes only once the block has gone quiet
   task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                            input logic o);
      logic [CFG_W-1:0] odata;
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      odata    = CFG_W'($urandom);
      odata[0] = o;
      csr_write(REG_FRAME_WIDTH, w);
      csr_write(REG_FRAME_HEIGHT, h);
      csr_write(REG_ORIENTATION, odata);
      if ($urandom_range(0, 3) == 0) csr_write(REG_SPARE, CFG_W'($urandom));
      csr_write_enable <= 1'b0;
   endtask

   // n frames at the current size; partial cuts the run short at a random pixel
   task automatic send_frames(input int n, input bit partial);
      int                 frame_px;
      int                 count;
      pattern_type        mode;
      logic [PIXEL_W-1:0] base;
      frame_px = sb.clamp_side(sb.width_reg) * sb.clamp_side(sb.height_reg);
      count    = n * frame_px;
      if (partial) count = $urandom_range(0, count - 1);
      mode = PAT_NOISE;
      base = '0;
      for (int i = 0; i < count; i++) begin
         if (i % frame_px == 0) begin
            mode = pattern_type'($urandom_range(0, 4));
            base = PIXEL_W'($urandom);
         end
         send_pixel(pattern_pixel(mode, i % frame_px, base));
      end
   endtask

   initial begin
      int start_count;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      req_valid        <= 1'b0;
      req_pixel        <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry, cut short by the writes that follow
      for (int i = 0; i < 8; i++) send_pixel(PIXEL_W'($urandom));

      // zero sizes act as a single pixel
      configure('0, '0, 1'b0);
      send_pixel(8'hFF);
      configure(12'd1, 12'd1, 1'b1);
      send_pixel(8'h00);
      // one rising step in the column band
      configure(12'd2, 12'd2, 1'b0);
      send_pixel(8'h00);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(8'hFF);
      // row band: only the second row counts
      configure(12'd3, 12'd2, 1'b1);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(8'h00);
      send_pixel(8'hFF);

      start_count = pixels_sent;
      while (pixels_sent - start_count < RANDOM_ITEMS) begin
         gaps_on = ($urandom_range(0, 4) != 0);
         configure(pick_side(), pick_side(), 1'($urandom_range(0, 1)));
         send_frames($urandom_range(1, 4), $urandom_range(0, 5) == 0);
      end

      // long receiver hold with tiny back-to-back frames fills the block
      gaps_on = 1'b0;
      configure(12'd3, 12'd2, 1'($urandom_range(0, 1)));
      hold_req = 1'b1;
      while (!in_hold) @(posedge clock);
      send_frames(20, 1'b0);

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

### files.f
design/bta_pkg.sv
design/bta_datapath.sv
design/bta_controller.sv
design/band_transition_averager.sv
tb/band_transition_averager_tb.sv
